// File: hw/rtl/tdat_pkg.sv
// Shared types, constants and the digit-pair decode for the time-of-day alarm table.
// Used by every module under hw/rtl; no dependencies.
`default_nettype none

package tdat_pkg;

   localparam int SlotCountDef = 8;
   localparam int TimeW        = 24;
   localparam int SlotNumW     = 6;
   localparam logic [7:0] AsciiZero = 8'd48;

   typedef enum logic [2:0] {
      ST_ADDED   = 3'd0,
      ST_FORMAT  = 3'd1,
      ST_FULL    = 3'd2,
      ST_FIRED   = 3'd3,
      ST_NOMATCH = 3'd4
   } status_type;

   typedef enum logic {
      CMD_ADD  = 1'b0,
      CMD_TICK = 1'b1
   } command_type;

   typedef struct packed {
      command_type command;
      logic        frame_ok;
      logic [7:0]  hour_tens_char;
      logic [7:0]  hour_units_char;
      logic [7:0]  minute_tens_char;
      logic [7:0]  minute_units_char;
      logic [7:0]  second_tens_char;
      logic [7:0]  second_units_char;
      logic [7:0]  now_hour;
      logic [7:0]  now_minute;
      logic [7:0]  now_second;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [SlotNumW-1:0] slot_number;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic clr_en;
   } tbl_cmd_type;

   // tens*10 + units after removing the ASCII offset, modulo 256
   function automatic logic [7:0] pair_value(input logic [7:0] tens, input logic [7:0] units);
      logic [7:0] t;
      logic [7:0] u;
      t = tens - AsciiZero;
      u = units - AsciiZero;
      return (t << 3) + (t << 1) + u;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tdat_decode.sv
// Builds the 24-bit time key from a request word: decoded digits on add, current time on tick.
// Depends on tdat_pkg.
`default_nettype none

module tdat_decode (
   input  wire tdat_pkg::req_type              req_word,
   output logic [tdat_pkg::TimeW-1:0]          key
);

   logic [7:0] hour;
   logic [7:0] minute;
   logic [7:0] second;

   assign hour   = tdat_pkg::pair_value(req_word.hour_tens_char, req_word.hour_units_char);
   assign minute = tdat_pkg::pair_value(req_word.minute_tens_char, req_word.minute_units_char);
   assign second = tdat_pkg::pair_value(req_word.second_tens_char, req_word.second_units_char);

   always_comb begin
      if (req_word.command == tdat_pkg::CMD_TICK) begin
         key = {req_word.now_hour, req_word.now_minute, req_word.now_second};
      end else begin
         key = {hour, minute, second};
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/tdat_table.sv
// Alarm time memory (one write port, one registered read port) and per-slot armed flags.
// Depends on tdat_pkg.
`default_nettype none

module tdat_table #(
   parameter int SLOT_COUNT = tdat_pkg::SlotCountDef,
   localparam int SlotW     = $clog2(SLOT_COUNT)
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire tdat_pkg::tbl_cmd_type        tbl_cmd,
   input  wire [SlotW-1:0]                   wr_addr,
   input  wire [tdat_pkg::TimeW-1:0]         wr_data,
   input  wire [SlotW-1:0]                   clr_addr,
   input  wire [SlotW-1:0]                   rd_addr,
   output logic [tdat_pkg::TimeW-1:0]        rd_data,
   input  wire [SlotW-1:0]                   arm_addr,
   output logic                              arm_bit
);

   logic [tdat_pkg::TimeW-1:0] mem_ff [SLOT_COUNT];
   logic [tdat_pkg::TimeW-1:0] rd_data_ff;
   logic [SLOT_COUNT-1:0]      armed_ff;
   logic [SLOT_COUNT-1:0]      armed_in;

   always_ff @(posedge clock) begin
      if (tbl_cmd.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_comb begin
      armed_in = armed_ff;
      if (tbl_cmd.wr_en) begin
         armed_in[wr_addr] = 1'b1;
      end
      if (tbl_cmd.clr_en) begin
         armed_in[clr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
      end else begin
         armed_ff <= armed_in;
      end
   end

   assign rd_data = rd_data_ff;
   assign arm_bit = armed_ff[arm_addr];

endmodule

`default_nettype wire

// File: hw/rtl/tdat_ctrl.sv
// Sequencer: add handling, slot scan through the shared time comparator, result register.
// Depends on tdat_pkg; drives tdat_table.
`default_nettype none

module tdat_ctrl #(
   parameter int SLOT_COUNT = tdat_pkg::SlotCountDef,
   localparam int SlotW     = $clog2(SLOT_COUNT),
   localparam int CntW      = $clog2(SLOT_COUNT + 1)
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire tdat_pkg::command_type        req_command,
   input  wire                               req_frame_ok,
   input  wire [tdat_pkg::TimeW-1:0]         req_key,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output tdat_pkg::rsp_type                 rsp_word,
   output tdat_pkg::tbl_cmd_type             tbl_cmd,
   output logic [SlotW-1:0]                  wr_addr,
   output logic [tdat_pkg::TimeW-1:0]        wr_data,
   output logic [SlotW-1:0]                  clr_addr,
   output logic [SlotW-1:0]                  rd_addr,
   input  wire [tdat_pkg::TimeW-1:0]         rd_data,
   output logic [SlotW-1:0]                  arm_addr,
   input  wire                               arm_bit
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_SCAN = 3'b100
   } state_type;

   state_type                  state_ff, state_in;
   tdat_pkg::command_type      cmd_ff, cmd_in;
   logic                       frame_ff, frame_in;
   logic [tdat_pkg::TimeW-1:0] key_ff, key_in;
   logic [CntW-1:0]            next_ff, next_in;
   logic [CntW-1:0]            idx_ff, idx_in;
   logic                       cmp_valid_ff, cmp_valid_in;
   logic [SlotW-1:0]           cmp_idx_ff, cmp_idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   tdat_pkg::rsp_type          rsp_ff, rsp_in;
   logic                       hit;
   logic                       issue;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign hit       = cmp_valid_ff && arm_bit && (rd_data == key_ff);
   assign issue     = idx_ff < next_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      frame_in     = frame_ff;
      key_in       = key_ff;
      next_in      = next_ff;
      idx_in       = idx_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      tbl_cmd      = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd_in   = req_command;
               frame_in = req_frame_ok;
               key_in   = req_key;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd_ff == tdat_pkg::CMD_ADD) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (!frame_ff) begin
                  rsp_in.status      = tdat_pkg::ST_FORMAT;
                  rsp_in.slot_number = '0;
               end else if (next_ff >= CntW'(SLOT_COUNT)) begin
                  rsp_in.status      = tdat_pkg::ST_FULL;
                  rsp_in.slot_number = '0;
               end else begin
                  tbl_cmd.wr_en      = 1'b1;
                  rsp_in.status      = tdat_pkg::ST_ADDED;
                  rsp_in.slot_number = (tdat_pkg::SlotNumW)'(next_ff);
                  next_in            = next_ff + CntW'(1);
               end
            end else begin
               idx_in   = CntW'(1);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (hit) begin
               tbl_cmd.clr_en     = 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_in.status      = tdat_pkg::ST_FIRED;
               rsp_in.slot_number = (tdat_pkg::SlotNumW)'(cmp_idx_ff);
               state_in           = S_IDLE;
            end else if (!issue) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = tdat_pkg::ST_NOMATCH;
               rsp_in.slot_number = '0;
               state_in           = S_IDLE;
            end else begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = idx_ff[SlotW-1:0];
               idx_in       = idx_ff + CntW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_ff      <= CntW'(1);
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_ff      <= next_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      frame_ff   <= frame_in;
      key_ff     <= key_in;
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign wr_addr   = next_ff[SlotW-1:0];
   assign wr_data   = key_ff;
   assign clr_addr  = cmp_idx_ff;
   assign rd_addr   = idx_ff[SlotW-1:0];
   assign arm_addr  = cmp_idx_ff;

endmodule

`default_nettype wire

// File: hw/rtl/time_of_day_alarm_table.sv
// Time-of-day alarm table, top level: decode, sequencer and slot table.
// Depends on tdat_pkg, tdat_decode, tdat_ctrl and tdat_table.
//
// Holds up to SLOT_COUNT-1 alarms in slots 1 to SLOT_COUNT-1 (slot 0 is never used) and takes
// one request word at a time. An add word turns six ASCII digits into hour, minute and second
// (no digit check, 8-bit wrap) and answers from the execute state: the new slot,
// format error (frame_ok low, checked first) or table full; slots are never freed. A tick word
// walks the slots below next_slot in order through one table read port and one 24-bit time
// comparator, one slot per cycle, disarms the first armed match and answers with its number,
// or no match. The answer sits in an output register; the next request is taken only once
// that answer has been taken.
`default_nettype none

module time_of_day_alarm_table #(
   parameter int SLOT_COUNT = tdat_pkg::SlotCountDef
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire tdat_pkg::req_type     req_word,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output tdat_pkg::rsp_type          rsp_word
);

   localparam int SlotW = $clog2(SLOT_COUNT);

   logic [tdat_pkg::TimeW-1:0] req_key;
   tdat_pkg::tbl_cmd_type      tbl_cmd;
   logic [SlotW-1:0]           wr_addr;
   logic [tdat_pkg::TimeW-1:0] wr_data;
   logic [SlotW-1:0]           clr_addr;
   logic [SlotW-1:0]           rd_addr;
   logic [tdat_pkg::TimeW-1:0] rd_data;
   logic [SlotW-1:0]           arm_addr;
   logic                       arm_bit;

   tdat_decode u_decode (
      .req_word (req_word),
      .key      (req_key)
   );

   tdat_ctrl #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_word.command),
      .req_frame_ok (req_word.frame_ok),
      .req_key      (req_key),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_word     (rsp_word),
      .tbl_cmd      (tbl_cmd),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .clr_addr     (clr_addr),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .arm_addr     (arm_addr),
      .arm_bit      (arm_bit)
   );

   tdat_table #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .tbl_cmd  (tbl_cmd),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .clr_addr (clr_addr),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .arm_addr (arm_addr),
      .arm_bit  (arm_bit)
   );

endmodule

`default_nettype wire

// File: bench/tdat_bench_pkg.sv
// Alarm table scoreboard: predicts each response from accepted request words and checks them.
// Depends on tdat_pkg for the request and response word types and the status codes.
`timescale 1ns / 100ps

package tdat_bench_pkg;

   class alarm_scoreboard;
      int unsigned       slot_count;
      int unsigned       next_slot;
      logic [23:0]       slot_time[64];
      bit                alarm_armed[64];
      tdat_pkg::rsp_type pending_q[$];
      int unsigned       mismatches;
      int unsigned       outcome_count[5];

      function new(int unsigned slots);
         slot_count = slots;
         next_slot  = 1;
         mismatches = 0;
         foreach (alarm_armed[i]) begin
            alarm_armed[i] = 1'b0;
            slot_time[i]   = '0;
         end
         foreach (outcome_count[i]) outcome_count[i] = 0;
      endfunction

      function logic [7:0] digit_pair(logic [7:0] tens, logic [7:0] units);
         logic [7:0] t;
         logic [7:0] u;
         t = tens - 8'd48;
         u = units - 8'd48;
         return 8'(t * 8'd10 + u);
      endfunction

      function void note_request(tdat_pkg::req_type w);
         tdat_pkg::rsp_type r;
         logic [23:0]       now;
         int unsigned       i;
         r.status      = tdat_pkg::ST_NOMATCH;
         r.slot_number = '0;
         if (w.command == tdat_pkg::CMD_ADD) begin
            if (!w.frame_ok) begin
               r.status = tdat_pkg::ST_FORMAT;
            end else if (next_slot >= slot_count) begin
               r.status = tdat_pkg::ST_FULL;
            end else begin
               slot_time[next_slot]   = {digit_pair(w.hour_tens_char, w.hour_units_char),
                                         digit_pair(w.minute_tens_char, w.minute_units_char),
                                         digit_pair(w.second_tens_char, w.second_units_char)};
               alarm_armed[next_slot] = 1'b1;
               r.status      = tdat_pkg::ST_ADDED;
               r.slot_number = 6'(next_slot);
               next_slot++;
            end
         end else begin
            now = {w.now_hour, w.now_minute, w.now_second};
            for (i = 1; i < next_slot; i++) begin
               if (alarm_armed[i] && slot_time[i] == now) begin
                  alarm_armed[i] = 1'b0;
                  r.status       = tdat_pkg::ST_FIRED;
                  r.slot_number  = 6'(i);
                  break;
               end
            end
         end
         outcome_count[int'(r.status)]++;
         pending_q.push_back(r);
      endfunction

      function void check_response(tdat_pkg::rsp_type got);
         tdat_pkg::rsp_type want;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response word: status %0d slot %0d",
                        got.status, got.slot_number);
            return;
         end
         want = pending_q.pop_front();
         if (got.status !== want.status || got.slot_number !== want.slot_number) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                        want.status, want.slot_number, got.status, got.slot_number);
         end
      endfunction
   endclass

endpackage

// File: bench/tb_top.sv
// Top-level bench for time_of_day_alarm_table: directed and random request words,
// bursty sender, stalling receiver and an idle watchdog. Depends on tdat_pkg and tdat_bench_pkg.
`timescale 1ns / 100ps

module tb_top;

   localparam int SLOT_COUNT   = tdat_pkg::SlotCountDef;
   localparam int RANDOM_WORDS = 1680;
   localparam int HOLD_AFTER   = 200;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 2000;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   tdat_pkg::req_type req_word    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   tdat_pkg::rsp_type rsp_word;
   logic              hold_active = 1'b0;

   tdat_bench_pkg::alarm_scoreboard sb;

   int unsigned burst_left   = 0;
   int unsigned adds_sent    = 0;
   int unsigned ticks_sent   = 0;
   int unsigned words_taken  = 0;
   int unsigned hold_left    = 0;
   bit          hold_done    = 1'b0;
   int unsigned pattern_age  = 0;
   logic [15:0] stall_pattern = 16'hFFFF;
   int unsigned idle_cycles  = 0;

   time_of_day_alarm_table #(.SLOT_COUNT(SLOT_COUNT)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] rand_char();
      if ($urandom_range(1) == 0) return 8'd48 + 8'($urandom_range(9));
      return 8'($urandom_range(255));
   endfunction

   function automatic tdat_pkg::req_type add_word(bit ok, logic [7:0] ht, logic [7:0] hu,
                                                  logic [7:0] mt, logic [7:0] mu,
                                                  logic [7:0] st, logic [7:0] su);
      tdat_pkg::req_type w;
      w.command           = tdat_pkg::CMD_ADD;
      w.frame_ok          = ok;
      w.hour_tens_char    = ht;
      w.hour_units_char   = hu;
      w.minute_tens_char  = mt;
      w.minute_units_char = mu;
      w.second_tens_char  = st;
      w.second_units_char = su;
      w.now_hour          = 8'($urandom_range(255));
      w.now_minute        = 8'($urandom_range(255));
      w.now_second        = 8'($urandom_range(255));
      return w;
   endfunction

   function automatic tdat_pkg::req_type tick_word(logic [7:0] h, logic [7:0] m,
                                                   logic [7:0] s);
      tdat_pkg::req_type w;
      w = add_word(1'($urandom_range(1)), rand_char(), rand_char(), rand_char(),
                   rand_char(), rand_char(), rand_char());
      w.command    = tdat_pkg::CMD_TICK;
      w.now_hour   = h;
      w.now_minute = m;
      w.now_second = s;
      return w;
   endfunction

   task automatic send_word(input tdat_pkg::req_type w);
      int unsigned gap;
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(w);
      if (w.command == tdat_pkg::CMD_ADD) adds_sent++;
      else ticks_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else if (!hold_active) begin
         gap = $urandom_range(12);
         burst_left = $urandom_range(1) ? $urandom_range(40) : $urandom_range(4);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_word);
            words_taken++;
         end
         if (!hold_done && words_taken >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready   <= 1'b0;
            hold_active <= 1'b1;
         end else begin
            if (pattern_age == 0) begin
               case ($urandom_range(2))
                  0: stall_pattern = 16'hFFFF;
                  1: stall_pattern = 16'($urandom) | 16'h0001;
                  default: stall_pattern = 16'($urandom) | 16'($urandom) | 16'h0001;
               endcase
               pattern_age = $urandom_range(16, 96);
            end
            pattern_age--;
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            rsp_ready   <= stall_pattern[0];
            hold_active <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      tdat_pkg::req_type w;
      int unsigned       n;
      int unsigned       idx;
      sb = new(SLOT_COUNT);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(tick_word(8'd0, 8'd0, 8'd0));
      send_word(add_word(1'b0, "0", "0", "0", "0", "0", "0"));
      send_word(add_word(1'b1, "0", "0", "0", "0", "0", "0"));
      send_word(add_word(1'b1, "2", "3", "5", "9", "5", "9"));
      send_word(add_word(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      send_word(add_word(1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      send_word(add_word(1'b1, "2", "3", "5", "9", "5", "9"));
      send_word(tick_word(8'd23, 8'd59, 8'd59));
      send_word(tick_word(8'd23, 8'd59, 8'd59));
      send_word(tick_word(8'd23, 8'd59, 8'd59));
      send_word(tick_word(8'd0, 8'd0, 8'd0));
      w = add_word(1'b1, "1", "2", "3", "4", "5", "6");
      w.now_hour   = 8'hFF;
      w.now_minute = 8'hFF;
      w.now_second = 8'hFF;
      send_word(w);
      send_word(tick_word(8'd255, 8'd255, 8'd255));
      send_word(tick_word(8'd229, 8'd229, 8'd229));
      send_word(add_word(1'b1, "9", "9", "9", "9", "9", "9"));
      send_word(add_word(1'b1, "0", "1", "0", "2", "0", "3"));
      send_word(add_word(1'b0, "0", "1", "0", "2", "0", "3"));
      send_word(tick_word(8'd1, 8'd2, 8'd3));

      for (n = 0; n < RANDOM_WORDS; n++) begin
         if ($urandom_range(9) < 3) begin
            w = add_word($urandom_range(3) != 0, rand_char(), rand_char(), rand_char(),
                         rand_char(), rand_char(), rand_char());
         end else if ($urandom_range(1) == 0) begin
            idx = $urandom_range(SLOT_COUNT - 1, 1);
            w = tick_word(sb.slot_time[idx][23:16], sb.slot_time[idx][15:8],
                          sb.slot_time[idx][7:0]);
         end else if ($urandom_range(1) == 0) begin
            w = tick_word(8'($urandom_range(23)), 8'($urandom_range(59)),
                          8'($urandom_range(59)));
         end else begin
            w = tick_word(8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255)));
         end
         send_word(w);
      end
      req_valid <= 1'b0;

      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (SLOT_COUNT + 4) @(posedge clock);

      $display("Covered %0d request words (%0d adds, %0d ticks) with bursty input, ",
               adds_sent + ticks_sent, adds_sent, ticks_sent,
               "random output stalls and one long output hold");
      $display("Outcomes: %0d added, %0d format error, %0d table full, %0d fired, %0d no match",
               sb.outcome_count[tdat_pkg::ST_ADDED], sb.outcome_count[tdat_pkg::ST_FORMAT],
               sb.outcome_count[tdat_pkg::ST_FULL], sb.outcome_count[tdat_pkg::ST_FIRED],
               sb.outcome_count[tdat_pkg::ST_NOMATCH]);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: time_of_day_alarm_table.f
hw/rtl/tdat_pkg.sv
hw/rtl/tdat_decode.sv
hw/rtl/tdat_table.sv
hw/rtl/tdat_ctrl.sv
hw/rtl/time_of_day_alarm_table.sv
bench/tdat_bench_pkg.sv
bench/tb_top.sv
